[rtl/core/imse_pkg.sv]
// Shared types, widths and helpers for the image mean-square-error block.
// Used by the top level, the divider and the port checker; no dependencies.
package imse_pkg;

   // Field widths
   localparam int PIX_W   = 16;
   localparam int DIM_W   = 13;
   localparam int CNT_W   = 25;
   localparam int SQ_W    = 2 * PIX_W;
   localparam int SUM_W   = 56;
   localparam int FRAC_W  = 8;
   localparam int MEAN_W  = 40;
   localparam int DIV_W   = SUM_W + FRAC_W;
   localparam int ITER_W  = $clog2(DIV_W);
   localparam int PROD_W  = 2 * DIM_W;

   // Frame geometry limits and reset geometry
   localparam int unsigned MAX_DIM = 4096;
   localparam logic [DIM_W-1:0] MAX_DIM_VAL      = DIM_W'(MAX_DIM);
   localparam logic [DIM_W-1:0] WIDTH_RESET_VAL  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET_VAL = DIM_W'(480);

   // Register indexes on the csr channel
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Request to the divider: start pulse plus operands
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } imse_div_req_type;

   // Status from the divider: done pulse plus held quotient
   typedef struct packed {
      logic              done;
      logic [MEAN_W-1:0] quotient;
   } imse_div_rsp_type;

   // Force a dimension register into 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      begin
         r = d;
         if (d == '0) begin
            r = DIM_W'(1);
         end else if (d > MAX_DIM_VAL) begin
            r = MAX_DIM_VAL;
         end
         return r;
      end
   endfunction

endpackage

[rtl/core/imse_divider.sv]
// Restoring divider for the frame mean: (sum << 8) / count, one quotient bit
// per cycle over one shared compare-and-subtract. Depends on imse_pkg.
module imse_divider
   import imse_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  imse_div_req_type div_req,
   output imse_div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvsr_ff, dvsr_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   // Shift in the next dividend bit and try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dvsr_ff};
      fits  = (trial >= {1'b0, dvsr_ff});
   end

   // Step the sequence
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         iter_in = '0;
         quo_in  = {div_req.sum, {FRAC_W{1'b0}}};
         rem_in  = '0;
         dvsr_in = div_req.count;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[MEAN_W-1:0];

endmodule

[rtl/core/image_mean_square_error.sv]
// Image mean-square-error top level: squaring, accumulation, frame count and
// the result register. Depends on imse_pkg and imse_divider.

// Each pixel pair passes through accept, square and accumulate before the next
// pair is taken; req_stall is high while a pair is in work. The last pixel of a
// frame (frame_width times frame_height pixels, each dimension clamped to
// 1..4096) starts a bit-serial divider, and req_stall stays high until the
// result is loaded into the output register. The result
// (exact sum and Q32.8 mean) sits in an output register, and the next frame's
// pixels are taken while it waits there. A frame end that finds the output
// register still holding an unaccepted result stalls the input until that
// result transfers. Write the dimensions only while the block is idle.
module image_mean_square_error
   import imse_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel_a,
   input  logic [PIX_W-1:0]     req_pixel_b,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SUM_W-1:0]     rsp_error_sum,
   output logic [MEAN_W-1:0]    rsp_mean_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [PIX_W-1:0]  pix_a_ff, pix_a_in;
   logic [PIX_W-1:0]  pix_b_ff, pix_b_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  hold_sum_ff, hold_sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [MEAN_W-1:0] rsp_mean_ff, rsp_mean_in;

   logic [PIX_W-1:0]  diff;
   logic [PROD_W-1:0] dim_prod;
   logic [SUM_W-1:0]  acc_sum;
   logic [CNT_W-1:0]  cnt_sum;
   logic              frame_end;
   logic              req_xfer;
   logic              out_free;

   imse_div_req_type  div_req;
   imse_div_rsp_type  div_rsp;

   imse_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Datapath helpers
   always_comb begin
      diff      = (pix_a_ff >= pix_b_ff) ? (pix_a_ff - pix_b_ff) : (pix_b_ff - pix_a_ff);
      dim_prod  = clamp_dim(width_ff) * clamp_dim(height_ff);
      acc_sum   = acc_ff + SUM_W'(sq_ff);
      cnt_sum   = cnt_ff + CNT_W'(1);
      frame_end = (cnt_sum >= total_ff);
      req_xfer  = req_valid && (state_ff == ST_IDLE);
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Sequencer and next values
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      total_in     = dim_prod[CNT_W-1:0];
      pix_a_in     = pix_a_ff;
      pix_b_in     = pix_b_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      hold_sum_in  = hold_sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      rsp_mean_in  = rsp_mean_ff;
      div_req      = '0;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pix_a_in = req_pixel_a;
               pix_b_in = req_pixel_b;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in    = diff * diff;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (frame_end) begin
               // Hand the frame to the divider and clear for the next one
               div_req.start = 1'b1;
               div_req.sum   = acc_sum;
               div_req.count = cnt_sum;
               hold_sum_in   = acc_sum;
               acc_in        = '0;
               cnt_in        = '0;
               state_in      = ST_DIVIDE;
            end else begin
               acc_in   = acc_sum;
               cnt_in   = cnt_sum;
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the result once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = hold_sum_ff;
               rsp_mean_in  = div_rsp.quotient;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RESET_VAL;
         height_ff    <= HEIGHT_RESET_VAL;
         total_ff     <= CNT_W'(WIDTH_RESET_VAL) * CNT_W'(HEIGHT_RESET_VAL);
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         total_ff     <= total_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_a_ff    <= pix_a_in;
      pix_b_ff    <= pix_b_in;
      sq_ff       <= sq_in;
      hold_sum_ff <= hold_sum_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_error_sum  = rsp_sum_ff;
   assign rsp_mean_error = rsp_mean_ff;

endmodule

[rtl/core/imse_checker.sv]
// Port-level checks for image_mean_square_error, attached by bind.
// Depends on imse_pkg for field widths.
module imse_checker
   import imse_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [SUM_W-1:0]     rsp_error_sum,
   input logic [MEAN_W-1:0]    rsp_mean_error
);

   // A pixel transfer always occupies the block for the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took a second pixel pair back to back");

   // The mean never exceeds the sum scaled to Q32.8
   a_mean_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({8'b0, rsp_mean_error} <= {rsp_error_sum, {FRAC_W{1'b0}}}))
      else $error("mean larger than scaled sum");

   // A new result appears only at the end of a busy stretch
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   // Hold a stalled result
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_error_sum) && $stable(rsp_mean_error))
      else $error("stalled result changed");

endmodule

bind image_mean_square_error imse_checker u_imse_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for image_mean_square_error: pixel-pair stream in,
// per-frame error sum and Q32.8 mean out. Depends on imse_pkg and the RTL.
module tb_top;
   import imse_pkg::*;

   // Run-length settings
   localparam int SETTLE_CYCLES  = 100;   // covers the frame-end divide
   localparam int HOLD_OFF_LEN   = 400;
   // Longest correct quiet stretch: hold-off plus divide plus settle
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 1750;
   localparam int TAIL_ITEMS     = 120;
   localparam int OVERSIZE_ITEMS = 48;

   typedef struct packed {
      logic [SUM_W-1:0]  error_sum;
      logic [MEAN_W-1:0] mean_error;
   } mse_result_type;

   typedef enum logic {ROW_GEOMETRY, ROW_PIXEL} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [PIX_W-1:0]  pixel_a;
      logic [PIX_W-1:0]  pixel_b;
      logic              typed;
      logic [SUM_W-1:0]  exp_sum;
      logic [MEAN_W-1:0] exp_mean;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 29;

   // Geometry rows set the frame; pixel rows with typed set carry the result
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // one-pixel frames: zero, full-scale both ways, alternating bits, equal
      '{ROW_GEOMETRY, 13'd1, 13'd1, 16'h0000, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0000, 16'h0000, 1'b1, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'hFFFF, 16'h0000, 1'b1,
        56'd4294836225, 40'd1099478073600},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0000, 16'hFFFF, 1'b1,
        56'd4294836225, 40'd1099478073600},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'hAAAA, 16'h5555, 1'b1,
        56'd477204025, 40'd122164230400},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h5555, 16'hAAAA, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h1234, 16'h1234, 1'b1, 56'd0, 40'd0},
      // zero dimensions act as one
      '{ROW_GEOMETRY, 13'd0, 13'd0, 16'h0000, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'hFFFF, 16'hFFFE, 1'b1, 56'd1, 40'd256},
      // 2x3 frame
      '{ROW_GEOMETRY, 13'd2, 13'd3, 16'h0000, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h000A, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0000, 16'h000A, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0003, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0000, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0001, 16'h0002, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0007, 16'h0007, 1'b1, 56'd210, 40'd8960},
      // shrink the frame mid-way: the next pixel closes it over six pixels
      '{ROW_GEOMETRY, 13'd4, 13'd4, 16'h0000, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0064, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0000, 16'h0064, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0032, 16'h003C, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h003C, 16'h0032, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'hFFFF, 16'hFFFF, 1'b0, 56'd0, 40'd0},
      '{ROW_GEOMETRY, 13'd1, 13'd2, 16'h0000, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0002, 16'h0000, 1'b1, 56'd20204, 40'd862037},
      // all-ones dimensions clamp to the maximum; no early frame end
      '{ROW_GEOMETRY, 13'h1FFF, 13'h1FFF, 16'h0000, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0001, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0000, 16'h0003, 1'b0, 56'd0, 40'd0},
      '{ROW_GEOMETRY, 13'd1, 13'd1, 16'h0000, 16'h0000, 1'b0, 56'd0, 40'd0},
      '{ROW_PIXEL, 13'd0, 13'd0, 16'h0000, 16'h0000, 1'b1, 56'd10, 40'd853}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel_a;
   logic [PIX_W-1:0]     req_pixel_b;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [SUM_W-1:0]     rsp_error_sum;
   logic [MEAN_W-1:0]    rsp_mean_error;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_data;

   // Predictor copy of the registers and the frame accumulator
   logic [DIM_W-1:0] geom_width;
   logic [DIM_W-1:0] geom_height;
   logic [CNT_W-1:0] acc_count;
   logic [SUM_W-1:0] acc_sum;

   mse_result_type mse_expected_q [$];
   int             mismatch_count;
   int             idle_cycles;
   int             gap_pct;
   int             stall_pct;
   int             hold_off_cycles;
   bit             quiet_tail;

   image_mean_square_error u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_a    (req_pixel_a),
      .req_pixel_b    (req_pixel_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_error_sum  (rsp_error_sum),
      .rsp_mean_error (rsp_mean_error),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Dimension as the block uses it: zero reads as one, oversize as the limit
   function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] d);
      return (d == '0) ? DIM_W'(1) : ((d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d);
   endfunction

   // Accumulate one pixel pair; return 1 with the frame result on a frame end
   function automatic bit predict_frame_mse(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            output mse_result_type res);
      logic [PIX_W-1:0]         diff;
      logic [2*DIM_W-1:0]       frame_pixels;
      logic [SUM_W+FRAC_W-1:0]  scaled;
      res = '0;
      diff = (a >= b) ? a - b : b - a;
      frame_pixels = effective_dim(geom_width) * effective_dim(geom_height);
      acc_sum = acc_sum + SUM_W'(diff) * SUM_W'(diff);
      acc_count = acc_count + 1'b1;
      if ((2*DIM_W)'(acc_count) < frame_pixels) return 1'b0;
      scaled = {acc_sum, {FRAC_W{1'b0}}};
      res.error_sum = acc_sum;
      res.mean_error = MEAN_W'(scaled / (SUM_W+FRAC_W)'(acc_count));
      acc_count = '0;
      acc_sum = '0;
      return 1'b1;
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel(input logic [PIX_W-1:0] other);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return other;
         3: return other + PIX_W'($urandom_range(0, 3));
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Mostly small frames; sometimes zero, the limit or oversize
   function automatic logic [DIM_W-1:0] random_dim();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
         2: return DIM_W'($urandom);
         3: return DIM_W'(MAX_DIM);
         default: return DIM_W'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   // Offer one pair, hold it until the transfer, then predict
   task automatic send_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                             input bit use_typed, input mse_result_type typed_result);
      mse_result_type res;
      bit             frame_end;
      req_valid   <= 1'b1;
      req_pixel_a <= a;
      req_pixel_b <= b;
      do @(posedge clock); while (req_stall);
      frame_end = predict_frame_mse(a, b, res);
      if (use_typed) mse_expected_q.push_back(typed_result);
      else if (frame_end) mse_expected_q.push_back(res);
      if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_random_pixels(input int count);
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      repeat (count) begin
         a = random_pixel(PIX_W'($urandom));
         b = random_pixel(a);
         send_pixel(a, b, 1'b0, '0);
      end
   endtask

   // Drop valid, wait for every outstanding result, then let the divider settle
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (mse_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data  <= w;
      do @(posedge clock); while (!csr_ready);
      geom_width = w;
      csr_index <= CSR_FRAME_HEIGHT;
      csr_data  <= h;
      do @(posedge clock); while (!csr_ready);
      geom_height = h;
      csr_valid <= 1'b0;
   endtask

   // Result checker: compare each transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      mse_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mse_expected_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result sum=%0d mean=%0d",
                                    rsp_error_sum, rsp_mean_error));
         end else begin
            want = mse_expected_q.pop_front();
            if (rsp_error_sum !== want.error_sum)
               note_mismatch($sformatf("error_sum expected %0d got %0d",
                                       want.error_sum, rsp_error_sum));
            if (rsp_mean_error !== want.mean_error)
               note_mismatch($sformatf("mean_error expected %0d got %0d",
                                       want.mean_error, rsp_mean_error));
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int burst;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            while (hold_off_cycles > 0) begin
               @(posedge clock);
               hold_off_cycles--;
            end
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
            burst = $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus
   initial begin
      int random_items;
      int phase;
      int count;
      mismatch_count  = 0;
      idle_cycles     = 0;
      hold_off_cycles = 0;
      quiet_tail      = 1'b0;
      gap_pct         = 25;
      stall_pct       = 25;
      geom_width      = WIDTH_RESET_VAL;
      geom_height     = HEIGHT_RESET_VAL;
      acc_count       = '0;
      acc_sum         = '0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_pixel_a <= '0;
      req_pixel_b <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_FRAME_WIDTH;
      csr_data    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_GEOMETRY) begin
            write_geometry(DIRECTED_ROWS[i].width, DIRECTED_ROWS[i].height);
         end else begin
            send_pixel(DIRECTED_ROWS[i].pixel_a, DIRECTED_ROWS[i].pixel_b,
                       DIRECTED_ROWS[i].typed,
                       mse_result_type'{DIRECTED_ROWS[i].exp_sum,
                                        DIRECTED_ROWS[i].exp_mean});
         end
      end

      // Random phases; frames often left open across a geometry change
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase++;
         gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
         stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
         if (phase == 4) begin
            // hold off the receiver while one-pixel frames keep coming
            write_geometry(DIM_W'(1), DIM_W'(1));
            gap_pct = 0;
            hold_off_cycles = HOLD_OFF_LEN;
            send_random_pixels(40);
            random_items += 40;
            wait_for_results();
         end else if (phase == 9) begin
            // oversize width clamps to the limit, zero height to one; frame stays open
            write_geometry(DIM_W'(MAX_DIM + 1), '0);
            send_random_pixels(OVERSIZE_ITEMS);
            random_items += OVERSIZE_ITEMS;
         end else if (phase == 15) begin
            write_geometry('0, DIM_W'(8191));
            send_random_pixels(OVERSIZE_ITEMS);
            random_items += OVERSIZE_ITEMS;
         end else begin
            if ($urandom_range(0, 3) != 0) write_geometry(random_dim(), random_dim());
            count = $urandom_range(1, 40);
            send_random_pixels(count);
            random_items += count;
            if ($urandom_range(0, 9) == 0) wait_for_results();
         end
      end

      // Tail with no idling on either side
      quiet_tail = 1'b1;
      write_geometry(DIM_W'($urandom_range(1, 4)), DIM_W'($urandom_range(1, 4)));
      send_random_pixels(TAIL_ITEMS);
      wait_for_results();

      if (mismatch_count == 0 && mse_expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
